>>> rtl/core/top_n_score_table_insert_unit_assert.svh
// ----------------------------------------------------------------------------
// Top-N score table insert unit: assertion macros
// Shared assertion forms for the checker of the insert unit.
// ----------------------------------------------------------------------------
`ifndef TOP_N_SCORE_TABLE_INSERT_UNIT_ASSERT_SVH
`define TOP_N_SCORE_TABLE_INSERT_UNIT_ASSERT_SVH

// same-cycle implication
`define TSI_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tsi assertion failed");

// next-cycle implication
`define TSI_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tsi assertion failed");

`endif

>>> rtl/core/tsi_pkg.sv
// ----------------------------------------------------------------------------
// Top-N score table insert: package
// Shared constants, opcode and the beat that travels down the cell chain.
// ----------------------------------------------------------------------------
package tsi_pkg;

    localparam int ENTRIES_DEF = 10;
    localparam int TABLES_DEF  = 3;

    localparam int SCORE_W = 32;
    localparam int TAG_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int DIFF_W  = 2;
    localparam int IDX_W   = 4;
    localparam int RANK_W  = 4;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 64;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef struct packed {
        logic                valid;
        op_t                 op;
        logic [DIFF_W-1:0]   tbl;
        logic [IDX_W-1:0]    idx;
        logic                active;
        logic                placed;
        logic [RANK_W-1:0]   rank;
        logic                hit;
        logic [SCORE_W-1:0]  score;
        logic [TAG_W-1:0]    tag;
        logic [LEVEL_W-1:0]  level;
    } pkt_t;

endpackage

>>> rtl/core/tsi_cell.sv
// ----------------------------------------------------------------------------
// Top-N score table insert: chain cell
// Holds one rank position of every table; swaps or captures the passing beat, or answers a read.
// ----------------------------------------------------------------------------
module tsi_cell #(
    parameter int TABLES = tsi_pkg::TABLES_DEF,
    parameter int K      = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  tsi_pkg::pkt_t pkt_i,
    output tsi_pkg::pkt_t pkt_o
);
    import tsi_pkg::*;

    localparam int TSEL_W = (TABLES > 1) ? $clog2(TABLES) : 1;
    localparam logic [RANK_W-1:0] MY_RANK = RANK_W'(K + 1);

    logic [SCORE_W-1:0] score_reg [TABLES];
    logic [TAG_W-1:0]   tag_reg   [TABLES];
    logic [LEVEL_W-1:0] level_reg [TABLES];
    logic [TABLES-1:0]  occ_reg, occ_next;
    pkt_t               pkt_reg, pkt_next;
    logic [TSEL_W-1:0]  tsel;
    logic               wr_en;

    always_comb begin
        tsel     = TSEL_W'(pkt_i.tbl);
        pkt_next = pkt_i;
        occ_next = occ_reg;
        wr_en    = 1'b0;
        if (pkt_i.valid) begin
            case (pkt_i.op)
                OP_INSERT: begin
                    if (pkt_i.active) begin
                        if (!occ_reg[tsel]) begin
                            wr_en           = 1'b1;
                            occ_next[tsel]  = 1'b1;
                            pkt_next.active = 1'b0;
                            if (!pkt_i.placed) begin
                                pkt_next.placed = 1'b1;
                                pkt_next.rank   = MY_RANK;
                            end
                        end else if (pkt_i.placed || (score_reg[tsel] < pkt_i.score)) begin
                            wr_en          = 1'b1;
                            pkt_next.score = score_reg[tsel];
                            pkt_next.tag   = tag_reg[tsel];
                            pkt_next.level = level_reg[tsel];
                            if (!pkt_i.placed) begin
                                pkt_next.placed = 1'b1;
                                pkt_next.rank   = MY_RANK;
                            end
                        end
                    end
                end
                OP_READ: begin
                    if (occ_reg[tsel] && (int'(pkt_i.idx) == K)) begin
                        pkt_next.hit   = 1'b1;
                        pkt_next.score = score_reg[tsel];
                        pkt_next.tag   = tag_reg[tsel];
                        pkt_next.level = level_reg[tsel];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
            pkt_reg <= '0;
        end else begin
            occ_reg <= occ_next;
            pkt_reg <= pkt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            score_reg[tsel] <= pkt_i.score;
            tag_reg[tsel]   <= pkt_i.tag;
            level_reg[tsel] <= pkt_i.level;
        end
    end

    assign pkt_o = pkt_reg;

endmodule

>>> rtl/core/top_n_score_table_insert_unit.sv
// An accepted beat goes through the head register and the cell chain; m_tvalid
// rises when its result is loaded into the output register.
// A new beat is taken once the previous one has reached the output register.
// Reset clears the occupancy of all tables; stored scores, tags and levels are kept.
// ----------------------------------------------------------------------------
// Top-N score table insert unit
// Sorted top-N tables per difficulty, built as a chain of rank-position cells.
// ----------------------------------------------------------------------------
module top_n_score_table_insert_unit #(
    parameter int ENTRIES = tsi_pkg::ENTRIES_DEF,
    parameter int TABLES  = tsi_pkg::TABLES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // new_score, entry_tag, entry_level, read_index, zero fill
    input  logic [tsi_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode, difficulty
    input  logic [tsi_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // placed, rank, out_valid, out_score, out_tag, out_level, zero fill
    output logic [tsi_pkg::M_TDATA_W-1:0]   m_tdata
);
    import tsi_pkg::*;

    localparam int RES_W = 1 + RANK_W + 1 + SCORE_W + TAG_W + LEVEL_W;

    pkt_t                 chain [ENTRIES+1];
    pkt_t                 head_reg, head_next;
    logic                 busy_reg, busy_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic [M_TDATA_W-1:0] hold_data_reg, hold_data_next;
    logic [M_TDATA_W-1:0] fin_data;
    logic [DIFF_W-1:0]    diff;
    logic                 accept, out_load, fin_ins, fin_hit;
    pkt_t                 fin;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign diff     = s_tuser[DIFF_W:1];

    always_comb begin
        head_next        = '0;
        head_next.valid  = accept;
        head_next.op     = op_t'(s_tuser[0]);
        head_next.tbl    = (int'(diff) >= TABLES) ? DIFF_W'(TABLES - 1) : diff;
        head_next.score  = s_tdata[SCORE_W-1:0];
        head_next.tag    = s_tdata[SCORE_W +: TAG_W];
        head_next.level  = s_tdata[SCORE_W+TAG_W +: LEVEL_W];
        head_next.idx    = s_tdata[SCORE_W+TAG_W+LEVEL_W +: IDX_W];
        head_next.active = 1'b1;
    end

    assign chain[0] = head_reg;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        tsi_cell #(
            .TABLES (TABLES),
            .K      (k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .pkt_i   (chain[k]),
            .pkt_o   (chain[k+1])
        );
    end

    assign fin     = chain[ENTRIES];
    assign fin_ins = (fin.op == OP_INSERT);
    assign fin_hit = (fin.op == OP_READ) && fin.hit;

    always_comb begin
        fin_data = '0;
        fin_data[RES_W-1:0] = {
            fin_hit ? fin.level : LEVEL_W'(0),
            fin_hit ? fin.tag   : TAG_W'(0),
            fin_hit ? fin.score : SCORE_W'(0),
            fin_hit,
            fin_ins ? fin.rank  : RANK_W'(0),
            fin_ins && fin.placed
        };
    end

    assign out_load = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;
        if (out_load) begin
            m_valid_next    = hold_valid_reg || fin.valid;
            m_data_next     = hold_valid_reg ? hold_data_reg : fin_data;
            hold_valid_next = 1'b0;
        end else if (fin.valid) begin
            hold_valid_next = 1'b1;
            hold_data_next  = fin_data;
        end
    end

    always_comb begin
        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (out_load && (fin.valid || hold_valid_reg)) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= '0;
            busy_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            head_reg       <= head_next;
            busy_reg       <= busy_next;
            m_valid_reg    <= m_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        hold_data_reg <= hold_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> rtl/core/tsi_check.sv
// ----------------------------------------------------------------------------
// Top-N score table insert: port checker
// Watches the stream ports of the insert unit over time.
// ----------------------------------------------------------------------------
`include "top_n_score_table_insert_unit_assert.svh"

module tsi_check (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tsi_pkg::M_TDATA_W-1:0] m_tdata
);
    import tsi_pkg::*;

    `TSI_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `TSI_ASSERT_IMP(a_rank_placed, aclk, aresetn, m_tvalid, m_tdata[0] == (m_tdata[RANK_W:1] != '0))
    `TSI_ASSERT_IMP(a_one_kind, aclk, aresetn, m_tvalid, !(m_tdata[0] && m_tdata[RANK_W+1]))
    `TSI_ASSERT_NXT(a_busy_after_beat, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind top_n_score_table_insert_unit tsi_check u_tsi_check (.*);
